// ===== rtl/pdu_pkg.sv =====
// shared types, constants and tables of the phase difference unit
package pdu_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int DIV_STEPS    = 33;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int XW           = 36;

  localparam logic [30:0] DEG_TURN = 31'd1509949440;
  localparam logic [30:0] DEG_HALF = 31'd754974720;
  localparam logic [30:0] PI_Q29   = 31'd1686629713;

  // DEG_TURN is 45 << 25; ceil(2^42 / 45) gives an exact quotient for 36-bit dividends
  localparam logic [36:0] RECIP_45 = 37'd97734366914;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    CMD_ZERO_CROSS = 2'd0,
    CMD_LAG        = 2'd1,
    CMD_FFT        = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_PERIOD = 2'd1,
    ST_BAD_BIN    = 2'd2,
    ST_ZERO_MAG   = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic        fft;
    logic        neg;
    logic [31:0] period;
    logic [31:0] aux;
  } side_t;

  typedef struct packed {
    side_t        side;
    logic [32:0]  mag;
    logic signed [32:0] xa;
    logic signed [32:0] ya;
    logic signed [32:0] xb;
    logic signed [32:0] yb;
    logic         za;
    logic         zb;
  } entry_t;

endpackage

// ===== rtl/pdu_front.sv =====
// front end: classifies a measurement and prepares its operands
module pdu_front (
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] time_a_i,
  input  logic signed [31:0] time_b_i,
  input  logic signed [31:0] lag_i,
  input  logic [31:0]        period_i,
  input  logic signed [31:0] re_a_i,
  input  logic signed [31:0] im_a_i,
  input  logic signed [31:0] re_b_i,
  input  logic signed [31:0] im_b_i,
  input  logic [15:0]        bin_number_i,
  input  logic [16:0]        bin_total_i,
  output pdu_pkg::entry_t    entry_o
);

  logic               fft;
  logic signed [32:0] nd;
  logic signed [32:0] ra, ia, rb, ib;

  always_comb begin
    fft = (cmd_i != pdu_pkg::CMD_ZERO_CROSS) && (cmd_i != pdu_pkg::CMD_LAG);
    if (cmd_i == pdu_pkg::CMD_ZERO_CROSS) begin
      nd = 33'(time_a_i) - 33'(time_b_i);
    end else begin
      nd = -33'(lag_i);
    end
    ra = 33'(re_a_i);
    ia = 33'(im_a_i);
    rb = 33'(re_b_i);
    ib = 33'(im_b_i);

    entry_o.side.fft    = fft;
    entry_o.side.neg    = nd[32];
    entry_o.side.period = period_i;
    entry_o.side.aux    = '0;
    entry_o.mag         = nd[32] ? 33'(-nd) : 33'(nd);
    entry_o.za          = ra[32];
    entry_o.zb          = rb[32];
    entry_o.xa          = ra[32] ? -ra : ra;
    entry_o.ya          = ra[32] ? -ia : ia;
    entry_o.xb          = rb[32] ? -rb : rb;
    entry_o.yb          = rb[32] ? -ib : ib;

    if (!fft) begin
      entry_o.side.status = (period_i == '0) ? pdu_pkg::ST_BAD_PERIOD : pdu_pkg::ST_OK;
    end else if (17'(bin_number_i) >= bin_total_i) begin
      entry_o.side.status = pdu_pkg::ST_BAD_BIN;
    end else if ((re_a_i == '0 && im_a_i == '0) || (re_b_i == '0 && im_b_i == '0)) begin
      entry_o.side.status = pdu_pkg::ST_ZERO_MAG;
    end else begin
      entry_o.side.status = pdu_pkg::ST_OK;
    end
  end

endmodule

// ===== rtl/pdu_queue.sv =====
// short queue between the front end and the back end
module pdu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pdu_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output pdu_pkg::entry_t entry_o,
  output logic            empty_o
);

  pdu_pkg::entry_t                 mem_q [pdu_pkg::QUEUE_DEPTH];
  logic [pdu_pkg::QPTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [pdu_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == pdu_pkg::QCNT_W'(pdu_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + pdu_pkg::QCNT_W'(do_push) - pdu_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pdu_pkg::QCNT_W'(pdu_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == pdu_pkg::QCNT_W'(pdu_pkg::QUEUE_DEPTH)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");
  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o)
    else $error("queue lost an entry while full");
`endif

endmodule

// ===== rtl/pdu_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module pdu_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  pdu_pkg::side_t      side_i,
  input  logic [31:0]         rem_i,
  input  logic [32:0]         num_i,
  input  logic [31:0]         den_i,
  output logic                vld_o,
  output pdu_pkg::side_t      side_o,
  output logic [32:0]         quo_o,
  output logic [31:0]         rem_o
);

  localparam int N = pdu_pkg::DIV_STEPS;

  logic                vld_q  [N];
  pdu_pkg::side_t      side_q [N];
  logic [31:0]         rem_q  [N];
  logic [32:0]         dq_q   [N];
  logic [31:0]         den_q  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                vp;
    pdu_pkg::side_t      sp;
    logic [31:0]         rp, dp;
    logic [32:0]         qp;
    logic [32:0]         t;
    logic                ge;

    if (i == 0) begin : g_first
      assign vp = vld_i;
      assign sp = side_i;
      assign rp = rem_i;
      assign qp = num_i;
      assign dp = den_i;
    end else begin : g_next
      assign vp = vld_q[i-1];
      assign sp = side_q[i-1];
      assign rp = rem_q[i-1];
      assign qp = dq_q[i-1];
      assign dp = den_q[i-1];
    end

    assign t  = {rp, qp[32]};
    assign ge = (t >= {1'b0, dp});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i] <= sp;
        den_q[i]  <= dp;
        rem_q[i]  <= ge ? 32'(t - {1'b0, dp}) : t[31:0];
        dq_q[i]   <= {qp[31:0], ge};
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign side_o = side_q[N-1];
  assign quo_o  = dq_q[N-1];
  assign rem_o  = rem_q[N-1];

endmodule

// ===== rtl/pdu_cordic.sv =====
// pipelined vectoring cordic, padded to the divider latency
module pdu_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] x_i,
  input  logic signed [32:0] y_i,
  input  logic               z_i,
  output logic [31:0]        z_o
);

  localparam int N  = pdu_pkg::DIV_STEPS;
  localparam int XW = pdu_pkg::XW;

  logic signed [XW-1:0] x_q [N];
  logic signed [XW-1:0] y_q [N];
  logic [31:0]          z_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [XW-1:0] xp, yp, xn, yn;
    logic [31:0]          zp, zn;

    if (i == 0) begin : g_first
      assign xp = XW'(x_i);
      assign yp = XW'(y_i);
      assign zp = {z_i, 31'd0};
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
    end

    if (i < pdu_pkg::CORDIC_STEPS) begin : g_rot
      always_comb begin
        if (yp > 0) begin
          xn = xp + (yp >>> i);
          yn = yp - (xp >>> i);
          zn = zp + pdu_pkg::ATAN_TURNS[i];
        end else begin
          xn = xp - (yp >>> i);
          yn = yp + (xp >>> i);
          zn = zp - pdu_pkg::ATAN_TURNS[i];
        end
      end
    end else begin : g_pad
      assign xn = xp;
      assign yn = yp;
      assign zn = zp;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= xn;
        y_q[i] <= yn;
        z_q[i] <= zn;
      end
    end
  end

  assign z_o = z_q[N-1];

endmodule

// ===== rtl/pdu_back.sv =====
// back end: remainder, angles, scaling and output register
module pdu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  pdu_pkg::entry_t entry_i,
  output logic            take_o,
  input  logic            pop_i,
  output logic            out_vld_o,
  output logic [30:0]     diff_deg_o,
  output logic [30:0]     phase_rad_o,
  output logic [1:0]      status_o
);

  logic           en;
  logic           out_vld_q;
  logic [30:0]    deg_out_q, rad_out_q;
  pdu_pkg::status_e st_out_q;

  assign en        = !out_vld_q || pop_i;
  assign take_o    = en;
  assign out_vld_o = out_vld_q;

  // remainder of the time difference and the two bin angles
  logic           v1;
  pdu_pkg::side_t s1;
  logic [32:0]    q1_unused;
  logic [31:0]    r1;
  logic [31:0]    za, zb;

  pdu_div u_mod (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld_i), .side_i(entry_i.side),
    .rem_i('0), .num_i(entry_i.mag), .den_i(entry_i.side.period),
    .vld_o(v1), .side_o(s1), .quo_o(q1_unused), .rem_o(r1)
  );

  pdu_cordic u_cordic_a (
    .clk_i, .en_i(en), .x_i(entry_i.xa), .y_i(entry_i.ya), .z_i(entry_i.za), .z_o(za)
  );

  pdu_cordic u_cordic_b (
    .clk_i, .en_i(en), .x_i(entry_i.xb), .y_i(entry_i.yb), .z_i(entry_i.zb), .z_o(zb)
  );

  // merge stage
  logic           v2_q;
  pdu_pkg::side_t s2_q;
  logic [31:0]    val2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s1;
      if (s1.fft) begin
        val2_q <= zb - za;
      end else if (s1.neg && r1 != '0) begin
        val2_q <= s1.period - r1;
      end else begin
        val2_q <= r1;
      end
    end
  end

  // product stage
  logic           v3_q;
  pdu_pkg::side_t s3_q, s3_d;
  logic [62:0]    n3_q;
  logic [40:0]    fprod;

  assign fprod = 41'(val2_q) * 41'd360 + 41'd512;

  always_comb begin
    s3_d     = s2_q;
    s3_d.aux = {1'b0, fprod[40:10]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
      n3_q <= 63'(pdu_pkg::DEG_TURN) * 63'(val2_q) + 63'(s2_q.period >> 1);
    end
  end

  // degree quotient
  logic           v4;
  pdu_pkg::side_t s4;
  logic [32:0]    q4;
  logic [31:0]    r4_unused;

  pdu_div u_deg (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v3_q), .side_i(s3_q),
    .rem_i(32'(n3_q[62:33])), .num_i(n3_q[32:0]), .den_i(s3_q.period),
    .vld_o(v4), .side_o(s4), .quo_o(q4), .rem_o(r4_unused)
  );

  // wrap stage
  logic               v5_q;
  pdu_pkg::side_t     s5_q, s5_d;
  logic [29:0]        mag5_q;
  logic [30:0]        deg_u;
  logic signed [31:0] deg_s;

  always_comb begin
    deg_u = s4.fft ? s4.aux[30:0] : q4[30:0];
    if (s4.status != pdu_pkg::ST_OK) begin
      deg_s = '0;
    end else if (deg_u >= pdu_pkg::DEG_HALF) begin
      deg_s = $signed({1'b0, deg_u}) - $signed({1'b0, pdu_pkg::DEG_TURN});
    end else begin
      deg_s = $signed({1'b0, deg_u});
    end
    s5_d     = s4;
    s5_d.neg = deg_s[31];
    s5_d.aux = deg_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q   <= s5_d;
      mag5_q <= deg_s[31] ? 30'(-deg_s) : deg_s[29:0];
    end
  end

  // radian product
  logic           v6_q;
  pdu_pkg::side_t s6_q;
  logic [60:0]    n6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q <= s5_q;
      n6_q <= 61'(mag5_q) * 61'(pdu_pkg::PI_Q29) + 61'(pdu_pkg::DEG_TURN >> 1);
    end
  end

  // radian quotient: drop 25 bits, then divide by 45 with a split reciprocal product
  logic           v7_q;
  pdu_pkg::side_t s7_q;
  logic [35:0]    m7;
  logic [54:0]    ph7_q, pl7_q;

  assign m7 = n6_q[60:25];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q  <= s6_q;
      ph7_q <= 55'(m7[35:18]) * 55'(pdu_pkg::RECIP_45);
      pl7_q <= 55'(m7[17:0]) * 55'(pdu_pkg::RECIP_45);
    end
  end

  logic           v8_q;
  pdu_pkg::side_t s8_q;
  logic [30:0]    q8_q;
  logic [72:0]    sum8;

  assign sum8 = {ph7_q, 18'd0} + 73'(pl7_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (en) begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q <= s7_q;
      q8_q <= sum8[72:42];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_out_q  <= s8_q.status;
      deg_out_q <= s8_q.aux[30:0];
      if (s8_q.status != pdu_pkg::ST_OK) begin
        rad_out_q <= '0;
      end else if (s8_q.neg) begin
        rad_out_q <= 31'(-q8_q);
      end else begin
        rad_out_q <= q8_q;
      end
    end
  end

  assign diff_deg_o  = deg_out_q;
  assign phase_rad_o = rad_out_q;
  assign status_o    = st_out_q;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !pop_i) |=> (out_vld_q && $stable(deg_out_q) && $stable(rad_out_q)))
    else $error("stalled result changed");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && st_out_q != pdu_pkg::ST_OK) |-> (deg_out_q == '0 && rad_out_q == '0))
    else $error("error result carries a phase");
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && rad_out_q != '0) |-> (rad_out_q[30] == deg_out_q[30]))
    else $error("degree and radian signs differ");
`endif

endmodule

// ===== rtl/phase_difference_unit.sv =====
// top level of the phase difference unit
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | push / full               | cmd, times, lag, period, bins, bin index
//  result   | pop / empty               | diff_deg, phase_rad, status
//
// one transfer in and one result out per cycle when unstalled
// from input transfer to result the path runs through the queue, two 33-stage dividers,
// merge, product, wrap, radian product, two reciprocal stages and output register
// the cordic lanes run beside the first divider and are padded to its length
// a held result stalls the whole back pipeline; the front queue holds four items
// no reset state beyond valid bits, queue pointers and queue count; reset empties both sides
module phase_difference_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] time_a_i,
  input  logic signed [31:0] time_b_i,
  input  logic signed [31:0] lag_i,
  input  logic [31:0]        period_i,
  input  logic signed [31:0] re_a_i,
  input  logic signed [31:0] im_a_i,
  input  logic signed [31:0] re_b_i,
  input  logic signed [31:0] im_b_i,
  input  logic [15:0]        bin_number_i,
  input  logic [16:0]        bin_total_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [30:0] diff_deg_o,
  output logic signed [30:0] phase_rad_o,
  output logic [1:0]         status_o
);

  pdu_pkg::entry_t front_entry, head_entry;
  logic            q_empty, take, out_vld;

  pdu_front u_front (
    .cmd_i, .time_a_i, .time_b_i, .lag_i, .period_i,
    .re_a_i, .im_a_i, .re_b_i, .im_b_i, .bin_number_i, .bin_total_i,
    .entry_o(front_entry)
  );

  pdu_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .entry_i(front_entry), .full_o(full),
    .pop_i(take), .entry_o(head_entry), .empty_o(q_empty)
  );

  pdu_back u_back (
    .clk_i, .rst_ni,
    .vld_i(!q_empty), .entry_i(head_entry), .take_o(take),
    .pop_i(pop), .out_vld_o(out_vld),
    .diff_deg_o, .phase_rad_o, .status_o
  );

  assign empty = !out_vld;

endmodule
